FILE: rtl/snz_pkg.sv
package snz_pkg;

   // Fixed-point constants
   localparam logic [31:0] SKEW_Q32   = 32'd1572067135;
   localparam logic [31:0] UNSKEW_Q32 = 32'd907633384;
   localparam logic [31:0] UNSKEW_Q24 = 32'd3545443;
   localparam logic [31:0] ONE_Q24    = 32'd16777216;
   localparam logic [47:0] HALF_Q48   = 48'd140737488355328;
   localparam logic [21:0] SCALE_Q16  = 22'd3008102;

   // Corner offsets are Q24, held in 32 bits (values stay within +-4)
   localparam int OFS_W  = 32;
   // Gradient value and per-corner term widths
   localparam int GRAD_W = 34;
   localparam int TERM_W = 34;
   localparam int SUM_W  = 36;

   // Permutation ROM
   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   function automatic logic [7:0] perm(input logic [7:0] idx);
      return PERM_ROM[idx];
   endfunction

   // Cell stage result: corner offsets (Q24) and first-level hashes
   typedef struct packed {
      logic signed [OFS_W-1:0] ax;
      logic signed [OFS_W-1:0] ay;
      logic signed [OFS_W-1:0] bx;
      logic signed [OFS_W-1:0] by;
      logic signed [OFS_W-1:0] cx;
      logic signed [OFS_W-1:0] cy;
      logic [7:0]              hi;
      logic                    stepx;
      logic [7:0]              hash0;
      logic [7:0]              hash1;
      logic [7:0]              hash2;
   } cell_out_type;

endpackage

FILE: rtl/simplex_noise_2d.sv
// 2D simplex noise, one sample per clock unless stalled. Each accepted item
// (x, y in signed fixed point with COORD_FRAC_BITS fraction bits) yields one
// saturated noise value with OUT_FRAC_BITS fraction bits. The pipeline takes a
// new item every cycle while not stalled; its depth is set by the multiplier
// chain (skew, unskew, squares, two falloff squares, gradient product, scale)
// plus the sum, at most one multiply per stage. A stall on the result side
// freezes every stage at once, so req_stall follows rsp_stall while a result is waiting.
module simplex_noise_2d #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int OUT_FRAC_BITS   = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise_value
);
   import snz_pkg::*;

   localparam int RW = 11 + OUT_FRAC_BITS;

   logic adv;
   logic cell_valid;
   cell_out_type cell_data;

   logic [6:0] vld_ff;
   logic rsp_valid_ff;

   logic [7:0] perm0, perm1, perm2;
   logic [2:0] code0_ff, code1_ff, code2_ff;
   logic signed [OFS_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [TERM_W-1:0] term0, term1, term2;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [58:0] scl_ff, scl_in;
   logic signed [RW-1:0] r;
   logic signed [15:0] out_ff, out_in;

   // Whole pipeline moves unless a held result is stalled
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   snz_cell #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_cell (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .x_coord  (req_x_coord),
      .y_coord  (req_y_coord),
      .out_valid(cell_valid),
      .out_data (cell_data)
   );

   // Second-level hash lookups
   always_comb begin
      perm0 = perm(cell_data.hi + cell_data.hash0);
      perm1 = perm(cell_data.hi + {7'd0, cell_data.stepx} + cell_data.hash1);
      perm2 = perm(cell_data.hi + 8'd1 + cell_data.hash2);
   end

   // Second-level hash to gradient codes
   always_ff @(posedge clock) begin
      if (adv) begin
         code0_ff <= perm0[2:0];
         code1_ff <= perm1[2:0];
         code2_ff <= perm2[2:0];
         ax_ff    <= cell_data.ax;
         ay_ff    <= cell_data.ay;
         bx_ff    <= cell_data.bx;
         by_ff    <= cell_data.by;
         cx_ff    <= cell_data.cx;
         cy_ff    <= cell_data.cy;
      end
   end

   snz_corner u_corner0 (
      .clock(clock), .adv(adv), .code(code0_ff), .dx(ax_ff), .dy(ay_ff), .term(term0)
   );
   snz_corner u_corner1 (
      .clock(clock), .adv(adv), .code(code1_ff), .dx(bx_ff), .dy(by_ff), .term(term1)
   );
   snz_corner u_corner2 (
      .clock(clock), .adv(adv), .code(code2_ff), .dx(cx_ff), .dy(cy_ff), .term(term2)
   );

   // Sum, scale, saturate
   always_comb begin
      sum_in = SUM_W'(term0) + SUM_W'(term1) + SUM_W'(term2);
      scl_in = 59'(sum_ff) * $signed({37'd0, SCALE_Q16});
      r      = $signed(scl_ff[58:48-OUT_FRAC_BITS]);
      if (r > RW'(32767)) begin
         out_in = 16'sd32767;
      end else if (r < -RW'(32768)) begin
         out_in = -16'sd32768;
      end else begin
         out_in = r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
         scl_ff <= scl_in;
         out_ff <= out_in;
      end
   end

   // Valid bits: hash stage, four corner stages, sum, scale, then output
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[5:0], cell_valid};
         rsp_valid_ff <= vld_ff[6];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = out_ff;

   // An advancing pipeline hands the last stage to the output
   a_out_follows: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid == $past(vld_ff[6]))
      else $error("output valid does not follow last stage");

   // A frozen pipeline keeps all its valid bits
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff) && rsp_valid)
      else $error("pipeline moved while stalled");

   // Input stall only when a held result is blocked
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule

FILE: rtl/snz_cell.sv
module snz_cell #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [31:0]   x_coord,
   input  logic signed [31:0]   y_coord,
   output logic                 out_valid,
   output snz_pkg::cell_out_type out_data
);
   import snz_pkg::*;

   localparam int CFB    = COORD_FRAC_BITS;
   localparam int CELL_W = 34 - CFB;
   localparam int IJ_W   = CELL_W + 1;
   localparam int TP_W   = IJ_W + 33;

   logic [3:0] vld_ff;

   logic signed [31:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic signed [32:0] s1_ff, s1_in;
   logic signed [CELL_W-1:0] ci2_ff, cj2_ff, ci3_ff, cj3_ff;
   logic signed [CELL_W-1:0] ci2_in, cj2_in;
   logic signed [34:0] t3_ff, t3_in;
   cell_out_type out_ff, out_in;

   logic signed [32:0] sum_xy;
   logic signed [65:0] s_prod;
   logic signed [33:0] pxs, pys;
   logic signed [IJ_W-1:0] ij;
   logic signed [TP_W-1:0] t_prod;
   logic signed [35:0] ax16, ay16;
   logic signed [39:0] axw, ayw;
   logic signed [OFS_W-1:0] ax, ay;
   logic stepx;
   logic [7:0] hj;

   // Stage 1: skew factor
   always_comb begin
      sum_xy = 33'(x_coord) + 33'(y_coord);
      s_prod = 66'(sum_xy) * $signed({34'd0, SKEW_Q32});
      s1_in  = $signed(s_prod[64:32]);
   end

   // Stage 2: cell origin, floored
   always_comb begin
      pxs    = 34'(x1_ff) + 34'(s1_ff);
      pys    = 34'(y1_ff) + 34'(s1_ff);
      ci2_in = $signed(pxs[33:CFB]);
      cj2_in = $signed(pys[33:CFB]);
   end

   // Stage 3: unskew of the cell origin
   always_comb begin
      ij     = IJ_W'(ci2_ff) + IJ_W'(cj2_ff);
      t_prod = TP_W'(ij) * $signed({(TP_W-32)'(0), UNSKEW_Q32});
      t3_in  = $signed(t_prod[66-CFB:32-CFB]);
   end

   // Stage 4: corner offsets, middle corner, first-level hashes
   always_comb begin
      ax16  = 36'(x3_ff) - (36'(ci3_ff) <<< CFB) + 36'(t3_ff);
      ay16  = 36'(y3_ff) - (36'(cj3_ff) <<< CFB) + 36'(t3_ff);
      axw   = 40'(ax16) <<< (24 - CFB);
      ayw   = 40'(ay16) <<< (24 - CFB);
      ax    = $signed(axw[OFS_W-1:0]);
      ay    = $signed(ayw[OFS_W-1:0]);
      stepx = (ax > ay);
      hj    = cj3_ff[7:0];
      out_in.ax    = ax;
      out_in.ay    = ay;
      out_in.bx    = ax - (stepx ? $signed(ONE_Q24) : '0) + $signed(UNSKEW_Q24);
      out_in.by    = ay - (stepx ? '0 : $signed(ONE_Q24)) + $signed(UNSKEW_Q24);
      out_in.cx    = ax - $signed(ONE_Q24) + $signed(UNSKEW_Q24 << 1);
      out_in.cy    = ay - $signed(ONE_Q24) + $signed(UNSKEW_Q24 << 1);
      out_in.hi    = ci3_ff[7:0];
      out_in.stepx = stepx;
      out_in.hash0 = perm(hj);
      out_in.hash1 = perm(hj + {7'd0, ~stepx});
      out_in.hash2 = perm(hj + 8'd1);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= x_coord;
         y1_ff  <= y_coord;
         s1_ff  <= s1_in;
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         ci2_ff <= ci2_in;
         cj2_ff <= cj2_in;
         x3_ff  <= x2_ff;
         y3_ff  <= y2_ff;
         ci3_ff <= ci2_ff;
         cj3_ff <= cj2_ff;
         t3_ff  <= t3_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = out_ff;

endmodule

FILE: rtl/snz_corner.sv
module snz_corner (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [2:0]                          code,
   input  logic signed [snz_pkg::OFS_W-1:0]    dx,
   input  logic signed [snz_pkg::OFS_W-1:0]    dy,
   output logic signed [snz_pkg::TERM_W-1:0]   term
);
   import snz_pkg::*;

   logic signed [63:0] sqx1_ff, sqy1_ff;
   logic signed [GRAD_W-1:0] g1_ff, g2_ff, g3_ff, g_in;
   logic [47:0] p2_ff, p2_in;
   logic [47:0] p4_ff, p4_in;
   logic neg2_ff, neg3_ff, neg_in;
   logic signed [TERM_W-1:0] term_ff, term_in;

   logic signed [GRAD_W-1:0] u, v, gu, gv;
   logic signed [65:0] fall;
   logic [23:0] f1, f2, f4;
   logic signed [58:0] tprod;

   // C1: gradient select; squares registered below
   always_comb begin
      u    = code[2] ? GRAD_W'(dx) : GRAD_W'(dy);
      v    = code[2] ? GRAD_W'(dy) : GRAD_W'(dx);
      gu   = code[0] ? -u : u;
      gv   = code[1] ? -(v <<< 1) : (v <<< 1);
      g_in = gu + gv;
   end

   // C2: falloff and first square
   always_comb begin
      fall   = $signed({18'd0, HALF_Q48}) - 66'(sqx1_ff) - 66'(sqy1_ff);
      neg_in = fall[65];
      f1     = fall[47:24];
      p2_in  = 48'(f1) * 48'(f1);
   end

   // C3: second square
   always_comb begin
      f2    = p2_ff[47:24];
      p4_in = 48'(f2) * 48'(f2);
   end

   // C4: falloff times gradient, floored to Q32
   always_comb begin
      f4      = p4_ff[47:24];
      tprod   = 59'($signed({1'b0, f4})) * 59'(g3_ff);
      term_in = neg3_ff ? '0 : $signed(tprod[TERM_W+15:16]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx1_ff <= 64'(dx) * 64'(dx);
         sqy1_ff <= 64'(dy) * 64'(dy);
         g1_ff   <= g_in;
         p2_ff   <= p2_in;
         neg2_ff <= neg_in;
         g2_ff   <= g1_ff;
         p4_ff   <= p4_in;
         neg3_ff <= neg2_ff;
         g3_ff   <= g2_ff;
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

FILE: verif/tb_simplex_noise_2d.sv
`timescale 1ns / 1ps

module tb_simplex_noise_2d;
   import snz_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_noise_value;

   simplex_noise_2d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise_value(rsp_noise_value)
   );

   always #2 clock = ~clock;

   localparam int FRAC = 16;
   localparam int OUTF = 15;
   localparam int PIPE_DEPTH = 12;

   logic signed [15:0] noise_expected [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Floor shift on 64 bits (arithmetic right shift)
   function automatic longint fshr(input longint v, input int k);
      return v >>> k;
   endfunction

   // 128-bit floor shift for the wide products
   function automatic longint fshr128(input logic signed [127:0] v, input int k);
      logic signed [127:0] r;
      r = v >>> k;
      return longint'(r);
   endfunction

   // One corner contribution in Q32
   function automatic longint corner_q32(input logic [7:0] code, input longint dx,
                                         input longint dy);
      longint fall, f1, f2, f4, u, v, g;
      logic signed [127:0] prod;
      fall = longint'(HALF_Q48) - dx * dx - dy * dy;
      if (fall < 0) return 0;
      f1 = fshr(fall, 24);
      f2 = fshr(f1 * f1, 24);
      f4 = fshr(f2 * f2, 24);
      u = code[2] ? dx : dy;
      v = code[2] ? dy : dx;
      g = code[0] ? -u : u;
      g = code[1] ? g - 2 * v : g + 2 * v;
      prod = 128'(signed'(f4)) * 128'(signed'(g));
      return fshr128(prod, 16);
   endfunction

   // Full noise sample for one coordinate pair
   function automatic logic signed [15:0] noise_of(input logic signed [31:0] xc,
                                                  input logic signed [31:0] yc);
      longint px, py, s, ci, cj, t, ax, ay, bx, by, cx, cy, sx, sy, sum, r;
      logic [7:0] hi, hj, h0, h1, h2;
      logic signed [127:0] wide;
      px = xc; py = yc;
      wide = 128'(signed'(px + py)) * 128'(longint'(SKEW_Q32));
      s = fshr128(wide, 32);
      ci = fshr(px + s, FRAC);
      cj = fshr(py + s, FRAC);
      t = fshr((ci + cj) * longint'(UNSKEW_Q32), 32 - FRAC);
      ax = (px - ci * (64'sd1 << FRAC) + t) * (64'sd1 << (24 - FRAC));
      ay = (py - cj * (64'sd1 << FRAC) + t) * (64'sd1 << (24 - FRAC));
      sx = (ax > ay) ? 1 : 0;
      sy = 1 - sx;
      bx = ax - sx * longint'(ONE_Q24) + longint'(UNSKEW_Q24);
      by = ay - sy * longint'(ONE_Q24) + longint'(UNSKEW_Q24);
      cx = ax - longint'(ONE_Q24) + 2 * longint'(UNSKEW_Q24);
      cy = ay - longint'(ONE_Q24) + 2 * longint'(UNSKEW_Q24);
      hi = ci[7:0]; hj = cj[7:0];
      h0 = PERM_ROM[8'(hi + PERM_ROM[hj])];
      h1 = PERM_ROM[8'(hi + 8'(sx) + PERM_ROM[8'(hj + 8'(sy))])];
      h2 = PERM_ROM[8'(hi + 8'd1 + PERM_ROM[8'(hj + 8'd1)])];
      sum = corner_q32(h0, ax, ay) + corner_q32(h1, bx, by) + corner_q32(h2, cx, cy);
      wide = 128'(signed'(sum)) * 128'(longint'(SCALE_Q16));
      r = fshr128(wide, 48 - OUTF);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // Send one item, with random idle cycles ahead of it
   task automatic send_point(input logic signed [31:0] xc, input logic signed [31:0] yc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_x_coord <= xc;
      req_y_coord <= yc;
      noise_expected.push_back(noise_of(xc, yc));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (noise_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item: %0d", rsp_noise_value);
         end else begin
            if (rsp_noise_value !== noise_expected[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("noise mismatch: expected %0d actual %0d",
                           noise_expected[0], rsp_noise_value);
            end
            void'(noise_expected.pop_front());
         end
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(2 * 65536 * 40)) - 65536 * 40);
         2: return 32'(signed'($urandom_range(2 * 65536 * 300)) - 65536 * 300);
         default: return 32'(signed'($urandom_range(4000)) - 2000);
      endcase
   endfunction

   // Extremes, signs, lattice points, ties and wrap of cell indices
   task automatic test_directed();
      send_point(32'sh0, 32'sh0);
      send_point(32'sh7fffffff, 32'sh7fffffff);
      send_point(32'sh80000000, 32'sh80000000);
      send_point(32'sh7fffffff, 32'sh80000000);
      send_point(32'sh80000000, 32'sh7fffffff);
      send_point(-32'sd1, -32'sd1);
      send_point(-32'sd65536, 32'sd65536);
      send_point(32'sd32768, 32'sd32768);
      send_point(32'sd16384, 32'sd16384);
      send_point(-32'sd30000, -32'sd12345);
      send_point(32'sd100000, 32'sd20000);
      send_point(32'sd20000, 32'sd100000);
      send_point(32'sd256 * 65536, 32'sd0);
      send_point(32'sd257 * 65536 + 1234, -32'sd255 * 65536);
      send_point(32'sh55555555, 32'shaaaaaaaa);
      send_point(32'shaaaaaaaa, 32'sh55555555);
      send_point(32'sd12000, 32'sd40000);
      send_point(32'sd40000, 32'sd12000);
   endtask

   task automatic test_random(input int n);
      repeat (n) send_point(rand_coord(), rand_coord());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 12; recv_idle_pct = 87;
      test_directed();
      test_random(260);
      send_idle_pct = 87; recv_idle_pct = 12;
      test_random(270);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(270);
      req_valid <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH * 3) @(posedge clock);
      if (mismatch_count == 0) $display("[simplex_noise_2d] OK");
      else $display("[simplex_noise_2d] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[simplex_noise_2d] ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/snz_pkg.sv
rtl/snz_cell.sv
rtl/snz_corner.sv
rtl/simplex_noise_2d.sv
verif/tb_simplex_noise_2d.sv
